// ===== rtl/core/sqi_pkg.sv =====
package sqi_pkg;

    // Queue capacity, the count width derived from it, and other widths
    localparam int DEPTH = 8;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 8;
    localparam int ECNT_W = 4;

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_ENQ = 2'd0,
        FUNC_DEQ = 2'd1,
        FUNC_INS = 2'd2
    } t_func;

    typedef struct packed {
        logic [1:0]              func;
        logic signed [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic                    accepted;
        logic signed [VAL_W-1:0] head_value;
        logic [ECNT_W-1:0]       entry_count;
        logic                    is_empty;
        logic                    is_full;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic push_tail;
        logic push_sorted;
        logic pop_head;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
    } t_stat;

endpackage

// ===== rtl/core/sorted_insert_queue_core.sv =====
// Sorted-insert queue: enqueue, dequeue and sorted insert on a shift-register chain.
// The result beat is registered; it is valid in the cycle after the input is taken.
// One operation per cycle unless the output stalls; all cells compare in parallel.
// Input is taken while the result register is empty or being drained the same cycle.
// Reset (synchronous, active low) empties the queue and the result slot;
// the cells themselves are not cleared.
module sorted_insert_queue_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  sqi_pkg::t_in i_in,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output sqi_pkg::t_out o_out
);
    import sqi_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sqi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_in.func),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sqi_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_value (i_in.value),
        .o_stat  (stat),
        .o_res   (o_out)
    );

endmodule

// ===== rtl/core/sqi_ctrl.sv =====
module sqi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [1:0]     i_func,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  sqi_pkg::t_stat i_stat,
    output sqi_pkg::t_cmd  o_cmd
);
    import sqi_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_HOLD
    } t_state;

    t_state r_state;
    logic   accept;

    // Take a beat whenever the result slot is free or drains this cycle
    assign o_in_ready = (r_state == ST_IDLE) || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Decode the operation against queue status
    always_comb begin
        o_cmd = '0;
        o_cmd.load = accept;
        unique case (t_func'(i_func))
            FUNC_ENQ: o_cmd.push_tail   = accept && !i_stat.full;
            FUNC_DEQ: o_cmd.pop_head    = accept && !i_stat.empty;
            FUNC_INS: o_cmd.push_sorted = accept && !i_stat.full;
            default:  o_cmd.load        = accept;
        endcase
    end

    // Track whether a result beat waits at the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: if (accept) r_state <= ST_HOLD;
                ST_HOLD: if (i_out_ready && !accept) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = (r_state == ST_HOLD);

endmodule

// ===== rtl/core/sqi_dpath.sv =====
module sqi_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sqi_pkg::t_cmd                  i_cmd,
    input  logic signed [sqi_pkg::VAL_W-1:0] i_value,
    output sqi_pkg::t_stat                 o_stat,
    output sqi_pkg::t_out                  o_res
);
    import sqi_pkg::*;

    logic signed [VAL_W-1:0] r_cell [DEPTH];
    logic signed [VAL_W-1:0] n_cell [DEPTH];
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic [DEPTH-1:0]        ge;
    logic [DEPTH-1:0]        at_or_after;
    logic [CNT_W+ECNT_W-1:0] cnt_ext;
    t_out                    r_res;
    t_out                    n_res;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));

    // Compare every stored cell against the new value at once
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ge[i] = i_cmd.push_sorted && (CNT_W'(i) < r_count) && (r_cell[i] >= i_value);
        end
    end

    // Mark cells at or past the insertion point
    always_comb begin
        at_or_after[0] = ge[0] || (r_count == '0);
        for (int i = 1; i < DEPTH; i++) begin
            at_or_after[i] = at_or_after[i-1] || ge[i] || (r_count == CNT_W'(i));
        end
    end

    // Next cell contents: shift toward tail on push, toward head on pop
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_cell[i] = r_cell[i];
            if (i_cmd.push_tail || i_cmd.push_sorted) begin
                if (at_or_after[i]) begin
                    if (i > 0 && at_or_after[(i > 0) ? i - 1 : 0]) begin
                        n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                    end else begin
                        n_cell[i] = i_value;
                    end
                end
            end else if (i_cmd.pop_head && i < DEPTH - 1) begin
                n_cell[i] = r_cell[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.push_tail || i_cmd.push_sorted) n_count = r_count + 1'b1;
        else if (i_cmd.pop_head)                  n_count = r_count - 1'b1;
    end

    // Form the result beat from the updated queue
    assign cnt_ext = {{ECNT_W{1'b0}}, n_count};
    always_comb begin
        n_res.accepted    = i_cmd.push_tail || i_cmd.push_sorted || i_cmd.pop_head;
        n_res.head_value  = (n_count != '0) ? n_cell[0] : '0;
        n_res.entry_count = cnt_ext[ECNT_W-1:0];
        n_res.is_empty    = (n_count == '0);
        n_res.is_full     = (n_count == CNT_W'(DEPTH));
    end

    // Hold cells and result; count is control state
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_cell[i] <= n_cell[i];
        end
        if (i_cmd.load) r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= '0;
        else          r_count <= n_count;
    end

    assign o_res = r_res;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond capacity");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push_tail || i_cmd.push_sorted) |-> !o_stat.full)
        else $error("push issued into a full queue");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop_head |=> r_count == CNT_W'($past(r_count) - 1'b1))
        else $error("pop did not decrement count");

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.push_tail, i_cmd.push_sorted, i_cmd.pop_head}))
        else $error("more than one queue operation at once");

endmodule

// ===== dv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sqi_pkg::*;

    // func code with no operation behind it
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int MAX_WAIT = 17;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_beat;
    logic out_valid;
    logic out_ready;
    t_out out_beat;

    // shadow of the queue contents, head at index 0
    logic signed [VAL_W-1:0] shadow_cells[$];
    // status beats still owed by the block, oldest first
    t_out pending_status[$];
    int mismatch_count = 0;
    // set while both sides run back to back
    bit no_idle = 1'b0;

    sorted_insert_queue_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_beat),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_beat)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    // Apply one operation to the shadow queue and return the status it leaves
    function automatic t_out apply_queue_op(t_in op);
        t_out st;
        int   pos;
        logic ok;
        ok = 1'b0;
        case (op.func)
            FUNC_ENQ: begin
                if (shadow_cells.size() < DEPTH) begin
                    shadow_cells.push_back(op.value);
                    ok = 1'b1;
                end
            end
            FUNC_DEQ: begin
                if (shadow_cells.size() > 0) begin
                    void'(shadow_cells.pop_front());
                    ok = 1'b1;
                end
            end
            FUNC_INS: begin
                if (shadow_cells.size() < DEPTH) begin
                    // go ahead of the first entry not less than the new value
                    pos = shadow_cells.size();
                    for (int i = 0; i < shadow_cells.size(); i++) begin
                        if (shadow_cells[i] >= op.value) begin
                            pos = i;
                            break;
                        end
                    end
                    shadow_cells.insert(pos, op.value);
                    ok = 1'b1;
                end
            end
            default: ok = 1'b0;
        endcase
        st.accepted    = ok;
        st.head_value  = (shadow_cells.size() > 0) ? shadow_cells[0] : '0;
        st.entry_count = ECNT_W'(shadow_cells.size());
        st.is_empty    = (shadow_cells.size() == 0);
        st.is_full     = (shadow_cells.size() == DEPTH);
        return st;
    endfunction

    // Send one beat. Valid is left high on return: the caller follows at once
    // with another send_op or with end_of_stimulus, so no duplicate is taken.
    task automatic send_op(input logic [1:0] func, input logic [VAL_W-1:0] value);
        int   gap;
        t_in  op;
        logic took;
        gap = draw_wait();
        op.func  = func;
        op.value = value;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= op;
        // sample ready mid-cycle, where it holds its value up to the next edge
        do begin
            @(negedge i_clk);
            took = in_ready;
            @(posedge i_clk);
        end while (!took);
        pending_status.push_back(apply_queue_op(op));
    endtask

    task automatic end_of_stimulus();
        in_valid <= 1'b0;
    endtask

    // Refused operations on an empty queue
    task automatic test_empty_refusals();
        send_op(FUNC_DEQ, 8'h00);
        send_op(FUNC_UNUSED, 8'hFF);
    endtask

    // Fill with extreme and alternating patterns, then push past full
    task automatic test_fill_overflow();
        logic [VAL_W-1:0] fill_vals[8];
        fill_vals = '{8'h7F, 8'h80, 8'h00, 8'hFF, 8'h01, 8'h55, 8'hAA, 8'h81};
        foreach (fill_vals[i]) send_op(FUNC_ENQ, fill_vals[i]);
        send_op(FUNC_ENQ, 8'h12);
        send_op(FUNC_INS, 8'h80);
        send_op(FUNC_UNUSED, 8'h00);
    endtask

    // Drain to empty, then one dequeue too many
    task automatic test_drain();
        repeat (DEPTH) send_op(FUNC_DEQ, 8'hFF);
        send_op(FUNC_DEQ, 8'h00);
    endtask

    // Sorted insert at both extremes and ahead of equal entries
    task automatic test_sorted_insert();
        send_op(FUNC_INS, 8'h03);
        send_op(FUNC_INS, 8'h80);
        send_op(FUNC_INS, 8'h7F);
        send_op(FUNC_INS, 8'h03);
        send_op(FUNC_INS, 8'h00);
    endtask

    function automatic logic [VAL_W-1:0] draw_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return ($urandom_range(0, 1) != 0) ? 8'h7F : 8'h80;
        // narrow band so ties show up often
        if (sel < 4) return VAL_W'($urandom_range(0, 6)) - 8'd3;
        return VAL_W'($urandom_range(0, 255));
    endfunction

    // Random chunks with a bias toward filling, draining or neither
    task automatic test_random_mix();
        int bias;
        int roll;
        logic [1:0] func;
        for (int chunk = 0; chunk < 18; chunk++) begin
            no_idle = ($urandom_range(0, 3) == 0);
            bias = $urandom_range(0, 2);
            for (int n = 0; n < 40; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 5) begin
                    func = FUNC_UNUSED;
                end else begin
                    case (bias)
                        0: func = (roll < 75) ? (roll[0] ? FUNC_INS : FUNC_ENQ) : FUNC_DEQ;
                        1: func = (roll < 30) ? (roll[0] ? FUNC_INS : FUNC_ENQ) : FUNC_DEQ;
                        default: func = (roll < 52) ? (roll[0] ? FUNC_INS : FUNC_ENQ)
                                                    : FUNC_DEQ;
                    endcase
                end
                send_op(func, draw_value());
            end
        end
        no_idle = 1'b0;
    endtask

    // Main sequence
    initial begin
        i_rst_n  <= 1'b0;
        in_valid <= 1'b0;
        in_beat  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_refusals();
        test_fill_overflow();
        test_drain();
        test_sorted_insert();
        test_random_mix();
        end_of_stimulus();
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Result side: stall at random, then compare each beat with the oldest expectation
    initial begin
        int   stall;
        t_out want;
        t_out seen;
        logic got;
        out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            // capture valid and payload mid-cycle, ahead of the accepting edge
            do begin
                @(negedge i_clk);
                got  = out_valid;
                seen = out_beat;
                @(posedge i_clk);
            end while (!got);
            if (pending_status.size() == 0) begin
                $error("status beat with no operation outstanding");
                mismatch_count++;
            end else begin
                want = pending_status.pop_front();
                if (seen.accepted !== want.accepted) begin
                    $error("accepted expected %0d got %0d", want.accepted, seen.accepted);
                    mismatch_count++;
                end
                if (seen.head_value !== want.head_value) begin
                    $error("head_value expected %0d got %0d",
                           want.head_value, seen.head_value);
                    mismatch_count++;
                end
                if (seen.entry_count !== want.entry_count) begin
                    $error("entry_count expected %0d got %0d",
                           want.entry_count, seen.entry_count);
                    mismatch_count++;
                end
                if (seen.is_empty !== want.is_empty) begin
                    $error("is_empty expected %0d got %0d", want.is_empty, seen.is_empty);
                    mismatch_count++;
                end
                if (seen.is_full !== want.is_full) begin
                    $error("is_full expected %0d got %0d", want.is_full, seen.is_full);
                    mismatch_count++;
                end
            end
        end
    end

    // Hang guard
    initial begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/sqi_pkg.sv
rtl/core/sqi_ctrl.sv
rtl/core/sqi_dpath.sv
rtl/core/sorted_insert_queue_core.sv
dv/testbench.sv
